[rtl/pcfj_pkg.sv]
`timescale 1ns / 1ps
package pcfj_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_VERTICES = 65536;
  localparam int VAL_W        = 48;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int GRAD_W       = COORD_W + 2;
  localparam int GAIN_W       = 32;
  localparam int VCOUNT_W     = 17;
  localparam int VERT_W       = 16;
  localparam int IDX_W        = 18;
  localparam int FMUL_LAT     = 4;
  localparam int QDEPTH       = 4;
  localparam int ENTRIES      = 6;
  localparam int ENTRY_W      = $clog2(ENTRIES);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VCOUNT    = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [1:0] axis_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [VERT_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic signed [COORD_W-1:0] vel_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    val_t             stiffness_entry;
    val_t             damping_entry;
    val_t             force_part;
    logic             force_valid;
    logic             last_entry;
  } out_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   stiffness_gain;
    logic [GAIN_W-1:0]   damping_gain;
    logic [VCOUNT_W-1:0] vertex_count;
  } cfg_t;

  // per-vertex scalars handed from front to back
  typedef struct packed {
    logic [VERT_W-1:0]           vert;
    logic [2:0][GRAD_W-1:0]      g;
    val_t                        twoc;
    val_t                        e;
    val_t                        kdcd;
  } qitem_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
    return s[VAL_W-1:0];
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
    return s[VAL_W-1:0];
  endfunction

  function automatic val_t ext_diff(logic [DIFF_W-1:0] x);
    return {{(VAL_W-DIFF_W){x[DIFF_W-1]}}, x};
  endfunction

  function automatic val_t ext_grad(logic [GRAD_W-1:0] x);
    return {{(VAL_W-GRAD_W){x[GRAD_W-1]}}, x};
  endfunction

  function automatic val_t ext_coord(logic [COORD_W-1:0] x);
    return {{(VAL_W-COORD_W){x[COORD_W-1]}}, x};
  endfunction

  function automatic val_t ext_gain(logic [GAIN_W-1:0] x);
    return {{(VAL_W-GAIN_W){1'b0}}, x};
  endfunction

  // lower-triangle walk: (0,0),(1,0),(1,1),(2,0),(2,1),(2,2)
  function automatic axis_t entry_row(entry_t k);
    case (k)
      3'd0:    return 2'd0;
      3'd1:    return 2'd1;
      3'd2:    return 2'd1;
      3'd3:    return 2'd2;
      3'd4:    return 2'd2;
      3'd5:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic axis_t entry_col(entry_t k);
    case (k)
      3'd0:    return 2'd0;
      3'd1:    return 2'd0;
      3'd2:    return 2'd1;
      3'd3:    return 2'd0;
      3'd4:    return 2'd1;
      3'd5:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

endpackage

[rtl/pcfj_fmul.sv]
`timescale 1ns / 1ps
module pcfj_fmul (
  input  logic          clk,
  input  logic          en,
  input  pcfj_pkg::val_t a,
  input  pcfj_pkg::val_t b,
  output pcfj_pkg::val_t y
);
  import pcfj_pkg::*;

  localparam int HALF   = VAL_W / 2;
  localparam int PROD_W = 2 * VAL_W;

  logic              neg1_r, neg2_r, neg3_r;
  logic [VAL_W-1:0]  ma_r, mb_r;
  logic [VAL_W-1:0]  ll_r, lh_r, hl_r, hh_r;
  logic [PROD_W-1:0] full_r;
  val_t              y_r;

  logic [VAL_W-1:0]  ma_nxt, mb_nxt;
  logic [VAL_W-1:0]  ll_nxt, lh_nxt, hl_nxt, hh_nxt;
  logic [PROD_W-1:0] full_nxt;
  logic [PROD_W-1:0] shifted, limit;
  logic [VAL_W-1:0]  mag;
  val_t              y_nxt;

  always_comb begin
    ma_nxt = a[VAL_W-1] ? (~a + 1'b1) : a;
    mb_nxt = b[VAL_W-1] ? (~b + 1'b1) : b;
    ll_nxt = ma_r[HALF-1:0] * mb_r[HALF-1:0];
    lh_nxt = ma_r[HALF-1:0] * mb_r[VAL_W-1:HALF];
    hl_nxt = ma_r[VAL_W-1:HALF] * mb_r[HALF-1:0];
    hh_nxt = ma_r[VAL_W-1:HALF] * mb_r[VAL_W-1:HALF];
    full_nxt = {hh_r, ll_r}
             + {{HALF{1'b0}}, lh_r, {HALF{1'b0}}}
             + {{HALF{1'b0}}, hl_r, {HALF{1'b0}}};
    // truncate toward zero on the magnitude, then clamp to the signed range
    shifted = full_r >> FRAC_BITS;
    limit   = neg3_r ? {{(PROD_W-VAL_W){1'b0}}, VAL_MIN}
                     : {{(PROD_W-VAL_W){1'b0}}, VAL_MAX};
    mag     = (shifted > limit) ? limit[VAL_W-1:0] : shifted[VAL_W-1:0];
    y_nxt   = neg3_r ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[VAL_W-1] ^ b[VAL_W-1];
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      neg2_r <= neg1_r;
      ll_r   <= ll_nxt;
      lh_r   <= lh_nxt;
      hl_r   <= hl_nxt;
      hh_r   <= hh_nxt;
      neg3_r <= neg2_r;
      full_r <= full_nxt;
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

[rtl/pcfj_front.sv]
`timescale 1ns / 1ps
module pcfj_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcfj_pkg::in_t     in_data,
  input  pcfj_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              push,
  output pcfj_pkg::qitem_t  push_data
);
  import pcfj_pkg::*;

  localparam int SUM_ST  = FMUL_LAT + 1;
  localparam int FB_ST   = SUM_ST + FMUL_LAT;
  localparam int LAST_ST = FB_ST + 1;
  localparam int TWOC_N  = FB_ST - SUM_ST + 1;

  typedef struct packed {
    logic [VERT_W-1:0]      vert;
    logic [2:0][GRAD_W-1:0] g;
  } fside_t;

  logic               fen;
  logic [LAST_ST:0]   vld_r;
  fside_t             side_r [0:FB_ST];
  fside_t             side_nxt;
  logic [DIFF_W-1:0]  d_r [0:2];
  logic [COORD_W-1:0] v_r [0:2];
  logic [DIFF_W-1:0]  d_nxt [0:2];
  logic [COORD_W-1:0] pos_in [0:2];
  logic [COORD_W-1:0] tgt_in [0:2];
  logic [COORD_W-1:0] vel_in [0:2];
  val_t               dd [0:2];
  val_t               gv [0:2];
  val_t               c_r, cdot_r, cd2_r;
  val_t               c_nxt, cdot_nxt;
  val_t               twoc_r [0:TWOC_N-1];
  val_t               ksc, kdcv, kdcd;
  qitem_t             item_r;

  assign fen      = !(vld_r[LAST_ST] && q_full);
  assign in_ready = fen;
  assign push     = vld_r[LAST_ST] && !q_full;
  assign push_data = item_r;

  assign pos_in[0] = in_data.pos_x;
  assign pos_in[1] = in_data.pos_y;
  assign pos_in[2] = in_data.pos_z;
  assign tgt_in[0] = in_data.target_x;
  assign tgt_in[1] = in_data.target_y;
  assign tgt_in[2] = in_data.target_z;
  assign vel_in[0] = in_data.vel_x;
  assign vel_in[1] = in_data.vel_y;
  assign vel_in[2] = in_data.vel_z;

  always_comb begin
    side_nxt.vert = in_data.vertex_index;
    for (int i = 0; i < 3; i++) begin
      d_nxt[i]      = {pos_in[i][COORD_W-1], pos_in[i]} - {tgt_in[i][COORD_W-1], tgt_in[i]};
      side_nxt.g[i] = {d_nxt[i], 1'b0};
    end
    // keep the running saturation of the sums in axis order
    c_nxt    = sat_add(sat_add(dd[0], dd[1]), dd[2]);
    cdot_nxt = sat_add(sat_add(gv[0], gv[1]), gv[2]);
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    pcfj_fmul u_dd (
      .clk (clk),
      .en  (fen),
      .a   (ext_diff(d_r[i])),
      .b   (ext_diff(d_r[i])),
      .y   (dd[i])
    );
    pcfj_fmul u_gv (
      .clk (clk),
      .en  (fen),
      .a   (ext_grad(side_r[0].g[i])),
      .b   (ext_coord(v_r[i])),
      .y   (gv[i])
    );
  end

  pcfj_fmul u_ksc (
    .clk (clk),
    .en  (fen),
    .a   (ext_gain(cfg.stiffness_gain)),
    .b   (c_r),
    .y   (ksc)
  );

  pcfj_fmul u_kdcv (
    .clk (clk),
    .en  (fen),
    .a   (ext_gain(cfg.damping_gain)),
    .b   (cdot_r),
    .y   (kdcv)
  );

  pcfj_fmul u_kdcd (
    .clk (clk),
    .en  (fen),
    .a   (ext_gain(cfg.damping_gain)),
    .b   (cd2_r),
    .y   (kdcd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (fen) begin
      vld_r <= {vld_r[LAST_ST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= d_nxt[i];
        v_r[i] <= vel_in[i];
      end
      side_r[0] <= side_nxt;
      for (int s = 1; s <= FB_ST; s++) begin
        side_r[s] <= side_r[s-1];
      end
      c_r       <= c_nxt;
      cdot_r    <= cdot_nxt;
      cd2_r     <= sat_add(cdot_nxt, cdot_nxt);
      twoc_r[0] <= sat_add(c_nxt, c_nxt);
      for (int s = 1; s < TWOC_N; s++) begin
        twoc_r[s] <= twoc_r[s-1];
      end
      item_r.vert <= side_r[FB_ST].vert;
      item_r.g    <= side_r[FB_ST].g;
      item_r.twoc <= twoc_r[TWOC_N-1];
      item_r.e    <= sat_add(ksc, kdcv);
      item_r.kdcd <= kdcd;
    end
  end

endmodule

[rtl/pcfj_queue.sv]
`timescale 1ns / 1ps
module pcfj_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pcfj_pkg::qitem_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output pcfj_pkg::qitem_t head
);
  import pcfj_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qitem_t           mem [0:QDEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a word");
`endif

endmodule

[rtl/pcfj_back.sv]
`timescale 1ns / 1ps
module pcfj_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pcfj_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  pcfj_pkg::qitem_t q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output pcfj_pkg::out_t   out_data
);
  import pcfj_pkg::*;

  localparam int M_ST   = FMUL_LAT;
  localparam int SM_ST  = M_ST + 1;
  localparam int D_ST   = SM_ST + FMUL_LAT;
  localparam int OUT_ST = D_ST + 1;
  localparam int F_N    = D_ST - SM_ST + 1;
  localparam entry_t LAST_K = ENTRY_W'(ENTRIES - 1);

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             diag;
    logic             last_entry;
    val_t             twoc;
    val_t             kdcd;
  } bside_t;

  logic                ben, issue;
  logic [OUT_ST:0]     vld_r;
  entry_t              k_r;
  axis_t               p, q;
  logic [VCOUNT_W-1:0] cnt;
  bside_t              side_nxt;
  bside_t              side_r [0:D_ST];
  logic [GRAD_W-1:0]   gp_r, gq_r;
  val_t                e_r;
  val_t                m_y, f0_y, dmp_y, stf_y;
  val_t                m_r, sm_r;
  val_t                f0_r [0:F_N-1];
  val_t                stiff_neg;
  out_t                out_r, out_nxt;

  // a stalled result freezes the whole back pipeline
  assign ben   = !(vld_r[OUT_ST] && !out_ready);
  assign issue = ben && q_valid;
  assign pop   = issue && (k_r == LAST_K);

  assign out_valid = vld_r[OUT_ST];
  assign out_data  = out_r;

  always_comb begin
    p   = entry_row(k_r);
    q   = entry_col(k_r);
    cnt = (cfg.vertex_count > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES)
                                                       : cfg.vertex_count;
    side_nxt.row        = IDX_W'(q_head.vert) + IDX_W'(cnt) * IDX_W'(p);
    side_nxt.col        = IDX_W'(q_head.vert) + IDX_W'(cnt) * IDX_W'(q);
    side_nxt.diag       = (p == q);
    side_nxt.last_entry = (k_r == LAST_K);
    side_nxt.twoc       = q_head.twoc;
    side_nxt.kdcd       = q_head.kdcd;

    stiff_neg = sat_sub('0, stf_y);
    out_nxt.row_index       = side_r[D_ST].row;
    out_nxt.col_index       = side_r[D_ST].col;
    out_nxt.stiffness_entry = side_r[D_ST].diag ? sat_sub(stiff_neg, side_r[D_ST].kdcd)
                                                : stiff_neg;
    out_nxt.damping_entry   = sat_sub('0, dmp_y);
    out_nxt.force_part      = side_r[D_ST].diag ? sat_sub('0, f0_r[F_N-1]) : '0;
    out_nxt.force_valid     = side_r[D_ST].diag;
    out_nxt.last_entry      = side_r[D_ST].last_entry;
  end

  pcfj_fmul u_m (
    .clk (clk),
    .en  (ben),
    .a   (ext_grad(gp_r)),
    .b   (ext_grad(gq_r)),
    .y   (m_y)
  );

  pcfj_fmul u_force (
    .clk (clk),
    .en  (ben),
    .a   (ext_grad(gp_r)),
    .b   (e_r),
    .y   (f0_y)
  );

  pcfj_fmul u_damp (
    .clk (clk),
    .en  (ben),
    .a   (ext_gain(cfg.damping_gain)),
    .b   (m_r),
    .y   (dmp_y)
  );

  pcfj_fmul u_stiff (
    .clk (clk),
    .en  (ben),
    .a   (ext_gain(cfg.stiffness_gain)),
    .b   (sm_r),
    .y   (stf_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      k_r   <= '0;
    end else begin
      if (ben) vld_r <= {vld_r[OUT_ST-1:0], q_valid};
      // hold the vertex at the head until its sixth entry is issued
      if (issue) k_r <= (k_r == LAST_K) ? '0 : k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      gp_r      <= q_head.g[p];
      gq_r      <= q_head.g[q];
      e_r       <= q_head.e;
      side_r[0] <= side_nxt;
      for (int s = 1; s <= D_ST; s++) begin
        side_r[s] <= side_r[s-1];
      end
      m_r     <= m_y;
      sm_r    <= side_r[M_ST].diag ? sat_add(m_y, side_r[M_ST].twoc) : m_y;
      f0_r[0] <= f0_y;
      for (int s = 1; s < F_N; s++) begin
        f0_r[s] <= f0_r[s-1];
      end
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n) (k_r != '0) |-> q_valid)
    else $error("vertex left the queue before all entries issued");
  a_offdiag_force: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_r.force_valid) |-> (out_r.force_part == '0))
    else $error("force on an off-diagonal word");
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_r.last_entry) |->
    (out_r.force_valid && (out_r.row_index == out_r.col_index)))
    else $error("final word of a vertex is not diagonal");
`endif

endmodule

[rtl/position_constraint_force_jacobian_top.sv]
`timescale 1ns / 1ps
// channel   handshake              payload
// ---------------------------------------------------------------
// in        in_valid / in_ready    in_data  (pcfj_pkg::in_t), one vertex
// out       out_valid / out_ready  out_data (pcfj_pkg::out_t), one entry
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (32 bits)
//
// Each vertex gives six words, one per cycle from the output register while
// out_ready is high and the queue holds a vertex.
// The front takes a vertex in any cycle its four-word queue has room.
// rst_n is synchronous; it clears the pipeline valids, queue, entry counter and cfg registers only.
// A low out_ready on a valid word freezes the back pipeline; the front runs on until the queue is full.
module position_constraint_force_jacobian_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pcfj_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pcfj_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcfj_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcfj_pkg::GAIN_W-1:0]      cfg_data
);
  import pcfj_pkg::*;

  cfg_t   cfg_r;
  logic   push, q_full, q_valid, pop;
  qitem_t push_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness_gain <= GAIN_W'(65536);
      cfg_r.damping_gain   <= GAIN_W'(65536);
      cfg_r.vertex_count   <= VCOUNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STIFFNESS: cfg_r.stiffness_gain <= cfg_data;
        REG_DAMPING:   cfg_r.damping_gain   <= cfg_data;
        REG_VCOUNT:    cfg_r.vertex_count   <= cfg_data[VCOUNT_W-1:0];
        default:       cfg_r                <= cfg_r;  // drop writes past the list
      endcase
    end
  end

  pcfj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pcfj_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  pcfj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
